### src/b64d_pkg.sv
// Shared types, codes and the character classifier for the Base64 stream decoder.
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned LenW   = 24;
  localparam int unsigned SextW  = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADCHAR  = 2'd1,
    ST_TOOSMALL = 2'd2,
    ST_SHORT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_ALPHA = 2'd0,
    CK_PAD   = 2'd1,
    CK_SPACE = 2'd2,
    CK_BAD   = 2'd3
  } char_kind_t;

  typedef struct packed {
    char_kind_t       kind;
    logic [SextW-1:0] val;
  } char_class_t;

  localparam logic [CharW-1:0] ChEnd = 8'h00;

  function automatic char_class_t classify(input logic [CharW-1:0] c);
    char_class_t r;
    logic [CharW-1:0] d;
    r.kind = CK_BAD;
    r.val  = '0;
    d      = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r.kind = CK_ALPHA;
      r.val  = d[SextW-1:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r.kind = CK_ALPHA;
      r.val  = d[SextW-1:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r.kind = CK_ALPHA;
      r.val  = d[SextW-1:0];
    end else if (c == 8'h2B) begin
      r.kind = CK_ALPHA;
      r.val  = 6'd62;
    end else if (c == 8'h2F) begin
      r.kind = CK_ALPHA;
      r.val  = 6'd63;
    end else if (c == 8'h3D) begin
      r.kind = CK_PAD;
    end else if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
      r.kind = CK_SPACE;
    end
    return r;
  endfunction

endpackage

### src/base64_stream_decoder.sv
// Base64 stream decoder: one character word in, decoded bytes and a final status out.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready | in_tdata[7:0] char_code (0 = end of string)
//  out_    | out | out_tvalid/out_tready | out_tdata[7:0] data_byte, [9:8] status_code,
//          |     |                       | out_tuser is_status, out_tlast last_of_run
//  cfg_    | in  | cfg_wr_en             | cfg_wr_data[23:0] expected_length
//
// Cycles: a character is captured in the input register, then decoded in one pass into
//   the result group register; one word per cycle when no results are pending.
// A character that yields results (a full quad, or the end of string) loads the group
//   register with 1 to 3 words, one per output handshake; the output port sets that rate.
// Characters that yield nothing pass the input register even while the output stalls.
// Reset (rst_n low, synchronous) clears decode state, pipeline valids and length register.
module base64_stream_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,    // [7:0] char_code
  // result words
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,   // [7:0] data_byte, [9:8] status_code
  output logic                       out_tuser,   // [0] is_status
  output logic                       out_tlast,   // last word caused by one input word
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [b64d_pkg::LenW-1:0]  cfg_wr_data  // expected_length
);
  import b64d_pkg::*;

  // decode phase: draining means '=' was seen, rest of string ignored
  typedef enum logic [1:0] {
    PH_DECODE = 2'd0,
    PH_DRAIN  = 2'd1,
    PH_ERROR  = 2'd2
  } phase_t;

  // length register
  logic [LenW-1:0]  exp_len_r;

  // input register
  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;

  // decode state
  logic [LenW-1:0]  acc_r,   acc_nxt;
  logic [1:0]       sext_r,  sext_nxt;
  logic [LenW-1:0]  bemit_r, bemit_nxt;
  phase_t           phase_r, phase_nxt;
  status_t          err_r,   err_nxt;

  // result group register: up to three data bytes and an optional status word
  logic             grp_valid_r;
  logic [1:0]       grp_idx_r;
  logic [7:0]       grp_b0_r, grp_b1_r, grp_b2_r;
  logic [1:0]       grp_cnt_r;
  logic             grp_stat_r;
  status_t          grp_code_r;

  logic [7:0]       grp_b0_nxt, grp_b1_nxt, grp_b2_nxt;
  logic [1:0]       grp_cnt_nxt;
  logic             grp_stat_nxt;
  status_t          grp_code_nxt;

  char_class_t      cls;
  logic [LenW-1:0]  acc_sh;
  logic [LenW:0]    bemit_ext, exp_ext;
  logic             has_res;
  logic             grp_free;
  logic             s1_adv;
  logic [2:0]       grp_total;
  logic             word_last;
  logic             out_hs;

  assign cls       = classify(s1_char_r);
  assign acc_sh    = {acc_r[LenW-SextW-1:0], cls.val};
  assign bemit_ext = {1'b0, bemit_r};
  assign exp_ext   = {1'b0, exp_len_r};

  // ---------------------------------------------------------------------------------
  // single decode pass on the registered character
  // ---------------------------------------------------------------------------------
  always_comb begin
    logic [LenW:0] be_tail;
    be_tail      = bemit_ext;
    acc_nxt      = acc_r;
    sext_nxt     = sext_r;
    bemit_nxt    = bemit_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    grp_b0_nxt   = '0;
    grp_b1_nxt   = '0;
    grp_b2_nxt   = '0;
    grp_cnt_nxt  = 2'd0;
    grp_stat_nxt = 1'b0;
    grp_code_nxt = ST_OK;

    if (s1_char_r == ChEnd) begin
      // end of string: flush the partial quad, check length, report status
      if (phase_r == PH_DECODE || phase_r == PH_DRAIN) begin
        if (sext_r == 2'd3) begin
          if (bemit_ext + 25'd2 > exp_ext) begin
            err_nxt = ST_TOOSMALL;
          end else begin
            grp_b0_nxt  = acc_r[17:10];
            grp_b1_nxt  = acc_r[9:2];
            grp_cnt_nxt = 2'd2;
            be_tail     = bemit_ext + 25'd2;
          end
        end else if (sext_r == 2'd2) begin
          if (bemit_ext + 25'd1 > exp_ext) begin
            err_nxt = ST_TOOSMALL;
          end else begin
            grp_b0_nxt  = acc_r[11:4];
            grp_cnt_nxt = 2'd1;
            be_tail     = bemit_ext + 25'd1;
          end
        end
        if (err_nxt == ST_OK && be_tail < exp_ext) begin
          err_nxt = ST_SHORT;
        end
      end
      grp_stat_nxt = 1'b1;
      grp_code_nxt = err_nxt;
      acc_nxt      = '0;
      sext_nxt     = 2'd0;
      bemit_nxt    = '0;
      phase_nxt    = PH_DECODE;
      err_nxt      = ST_OK;
    end else if (phase_r == PH_DECODE) begin
      case (cls.kind)
        CK_PAD: begin
          phase_nxt = PH_DRAIN;
        end
        CK_SPACE: begin
        end
        CK_BAD: begin
          err_nxt   = ST_BADCHAR;
          phase_nxt = PH_ERROR;
        end
        CK_ALPHA: begin
          acc_nxt = acc_sh;
          if (sext_r != 2'd3) begin
            sext_nxt = sext_r + 2'd1;
          end else if (bemit_ext + 25'd3 > exp_ext) begin
            err_nxt   = ST_TOOSMALL;
            phase_nxt = PH_ERROR;
          end else begin
            grp_b0_nxt  = acc_sh[23:16];
            grp_b1_nxt  = acc_sh[15:8];
            grp_b2_nxt  = acc_sh[7:0];
            grp_cnt_nxt = 2'd3;
            bemit_nxt   = bemit_r + 24'd3;
            acc_nxt     = '0;
            sext_nxt    = 2'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------------
  assign grp_total = {1'b0, grp_cnt_r} + {2'b0, grp_stat_r};
  assign word_last = ({1'b0, grp_idx_r} == grp_total - 3'd1);
  assign out_hs    = grp_valid_r && out_tready;
  assign grp_free  = !grp_valid_r || (out_tready && word_last);
  assign has_res   = (grp_cnt_nxt != 2'd0) || grp_stat_nxt;
  assign s1_adv    = s1_valid_r && (!has_res || grp_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // output word select
  always_comb begin
    out_tvalid = grp_valid_r;
    out_tdata  = '0;
    out_tuser  = 1'b0;
    out_tlast  = word_last;
    if (grp_idx_r < grp_cnt_r) begin
      case (grp_idx_r)
        2'd0:    out_tdata[7:0] = grp_b0_r;
        2'd1:    out_tdata[7:0] = grp_b1_r;
        default: out_tdata[7:0] = grp_b2_r;
      endcase
    end else begin
      out_tuser      = 1'b1;
      out_tdata[9:8] = grp_code_r;
    end
  end

  // ---------------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= '0;
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      sext_r      <= 2'd0;
      bemit_r     <= '0;
      phase_r     <= PH_DECODE;
      err_r       <= ST_OK;
      grp_valid_r <= 1'b0;
      grp_idx_r   <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        exp_len_r <= cfg_wr_data;
      end

      if (in_tready) begin
        s1_valid_r <= in_tvalid;
        s1_char_r  <= in_tdata;
      end

      if (s1_adv) begin
        acc_r   <= acc_nxt;
        sext_r  <= sext_nxt;
        bemit_r <= bemit_nxt;
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
      end

      if (grp_free) begin
        if (s1_adv && has_res) begin
          grp_valid_r <= 1'b1;
          grp_idx_r   <= 2'd0;
          grp_b0_r    <= grp_b0_nxt;
          grp_b1_r    <= grp_b1_nxt;
          grp_b2_r    <= grp_b2_nxt;
          grp_cnt_r   <= grp_cnt_nxt;
          grp_stat_r  <= grp_stat_nxt;
          grp_code_r  <= grp_code_nxt;
        end else begin
          grp_valid_r <= 1'b0;
        end
      end else if (out_hs) begin
        grp_idx_r <= grp_idx_r + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------------
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid_r |-> ({1'b0, grp_idx_r} < grp_total))
    else $error("group word index past group size");

  a_end_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_char_r == ChEnd) |=> (grp_valid_r && grp_stat_r))
    else $error("end of string did not load a status word");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("status word not last of its run");

  a_data_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[15:8] == 8'h00))
    else $error("data word carries a status code");

endmodule

### bench/base64_stream_decoder_tb.sv
// Self-checking bench for the Base64 stream decoder: directed strings, then random traffic.
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
  import b64d_pkg::*;

  // watchdog: cycles in a row with no word moving on either side
  localparam int unsigned StallLimit = 4000;
  // cycles the input pipe may still hold a silent word after the last result
  localparam int unsigned PipeDrain  = 6;
  localparam int unsigned MaxPrinted = 40;

  localparam logic [7:0] ChPad   = 8'h3D;  // '='
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [LenW-1:0] LenMax = '1;

  // decoder phase as the bench tracks it
  typedef enum logic [1:0] {
    DEC_RUN   = 2'd0,
    DEC_DRAIN = 2'd1,
    DEC_FAIL  = 2'd2
  } dec_phase_t;

  // one result word, field by field
  typedef struct {
    logic [7:0] data;
    logic       is_status;
    status_t    code;
    logic       last;
  } out_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;     // [7:0] char_code
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;         // [7:0] data_byte, [9:8] status_code
  logic             out_tuser;         // [0] is_status
  logic             out_tlast;
  logic             cfg_wr_en = 1'b0;
  logic [LenW-1:0]  cfg_wr_data = '0;

  base64_stream_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // -------------------------------------------------------------------------
  // Bench-side copy of the decoder state
  // -------------------------------------------------------------------------
  logic [LenW-1:0] want_len = '0;      // mirror of expected_length
  logic [23:0]     quad_acc = '0;
  logic [1:0]      quad_fill = '0;     // sextets held in current quad
  int unsigned     bytes_out = 0;
  dec_phase_t      dec_phase = DEC_RUN;
  status_t         held_err = ST_OK;

  out_word_t       expected_words[$];

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     chars_sent = 0;
  int unsigned     strings_sent = 0;
  int unsigned     words_checked = 0;
  int unsigned     len_writes = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     stall_cycles = 0;

  initial forever #6 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic char_kind_t sort_char(input logic [7:0] c, output logic [5:0] sextet);
    sextet = '0;
    if (c >= "A" && c <= "Z") begin
      sextet = 6'(c - "A");
      return CK_ALPHA;
    end
    if (c >= "a" && c <= "z") begin
      sextet = 6'(c - "a" + 26);
      return CK_ALPHA;
    end
    if (c >= "0" && c <= "9") begin
      sextet = 6'(c - "0" + 52);
      return CK_ALPHA;
    end
    if (c == "+") begin
      sextet = 6'd62;
      return CK_ALPHA;
    end
    if (c == "/") begin
      sextet = 6'd63;
      return CK_ALPHA;
    end
    if (c == ChPad) return CK_PAD;
    if ((c >= ChTab && c <= ChCr) || c == ChSpace) return CK_SPACE;
    return CK_BAD;
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic is_status,
                                    input status_t code, input logic last);
    out_word_t w;
    w.data      = data;
    w.is_status = is_status;
    w.code      = code;
    w.last      = last;
    expected_words.push_back(w);
  endfunction

  function automatic void latch_error(input status_t code);
    held_err  = code;
    dec_phase = DEC_FAIL;
  endfunction

  // advance the state by one accepted character and queue the words it causes
  function automatic void predict_decode(input logic [7:0] c);
    logic [5:0] sextet;
    char_kind_t kind;
    if (c == ChEnd) begin
      if (dec_phase != DEC_FAIL) begin
        // flush a partial quad: three sextets give two bytes, two give one
        if (quad_fill == 2'd3) begin
          if (bytes_out + 2 > want_len) latch_error(ST_TOOSMALL);
          else begin
            push_word(quad_acc[17:10], 1'b0, ST_OK, 1'b0);
            push_word(quad_acc[9:2], 1'b0, ST_OK, 1'b0);
            bytes_out += 2;
          end
        end else if (quad_fill == 2'd2) begin
          if (bytes_out + 1 > want_len) latch_error(ST_TOOSMALL);
          else begin
            push_word(quad_acc[11:4], 1'b0, ST_OK, 1'b0);
            bytes_out += 1;
          end
        end
        if (dec_phase != DEC_FAIL && bytes_out < want_len) latch_error(ST_SHORT);
      end
      push_word(8'h00, 1'b1, held_err, 1'b1);
      quad_acc  = '0;
      quad_fill = '0;
      bytes_out = 0;
      dec_phase = DEC_RUN;
      held_err  = ST_OK;
      return;
    end
    if (dec_phase != DEC_RUN) return;   // after '=' or an error, drop until end
    kind = sort_char(c, sextet);
    case (kind)
      CK_PAD:   dec_phase = DEC_DRAIN;
      CK_SPACE: ;
      CK_BAD:   latch_error(ST_BADCHAR);
      default: begin
        quad_acc = {quad_acc[17:0], sextet};
        if (quad_fill != 2'd3) quad_fill = quad_fill + 2'd1;
        else if (bytes_out + 3 > want_len) latch_error(ST_TOOSMALL);
        else begin
          push_word(quad_acc[23:16], 1'b0, ST_OK, 1'b0);
          push_word(quad_acc[15:8], 1'b0, ST_OK, 1'b0);
          push_word(quad_acc[7:0], 1'b0, ST_OK, 1'b1);
          bytes_out += 3;
          quad_acc  = '0;
          quad_fill = '0;
        end
      end
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random backpressure, checking, watchdog
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("[%0t] MISMATCH %s: got 0x%0h want 0x%0h (word %0d)",
               $realtime, what, got, want, words_checked);
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, data", out_tdata, 0);
        end else begin
          w = expected_words.pop_front();
          if (out_tdata[7:0] !== w.data) report_mismatch("data_byte", out_tdata[7:0], w.data);
          if (out_tdata[9:8] !== w.code) report_mismatch("status_code", out_tdata[9:8], w.code);
          if (out_tuser !== w.is_status) report_mismatch("is_status", out_tuser, w.is_status);
          if (out_tlast !== w.last) report_mismatch("last_of_run", out_tlast, w.last);
        end
        words_checked++;
      end
      // watchdog: any accepted word on either side resets the count
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles, %0d words still due",
                 StallLimit, expected_words.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side helpers
  // -------------------------------------------------------------------------
  // send one character word; returns right after the accepting edge with tvalid still high
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_decode(c);
    chars_sent++;
    if (c == ChEnd) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // hold the sender until every queued result has arrived
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // length register changes only with the pipe empty
  task automatic apply_length(input logic [LenW-1:0] len);
    hold_until_drained();
    repeat (PipeDrain) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    want_len = len;
    len_writes++;
  endtask

  function automatic logic [7:0] alphabet_char(input int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] space_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? ChSpace : 8'(ChTab + r);
  endfunction

  // one random string plus its end word; mostly well formed with a matching length
  task automatic send_random_string(input bit hold_before_end);
    logic [7:0]      text[$];
    int unsigned     quads;
    int unsigned     rest;
    int unsigned     n_out;
    logic [LenW-1:0] len;
    if ($urandom_range(9) == 0) begin
      // junk: any nonzero bytes
      repeat ($urandom_range(8)) text.push_back(8'($urandom_range(255, 1)));
      n_out = $urandom_range(6);
    end else begin
      quads = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
      rest  = $urandom_range(3);
      repeat (4 * quads + rest) text.push_back(alphabet_char($urandom_range(63)));
      if (rest >= 2 && $urandom_range(3) != 0) repeat (4 - rest) text.push_back(ChPad);
      // stray characters after padding are dropped by the block
      if ($urandom_range(4) == 0) text.push_back(alphabet_char($urandom_range(63)));
      n_out = 3 * quads + ((rest == 3) ? 2 : (rest == 2) ? 1 : 0);
      if ($urandom_range(3) == 0) text.insert($urandom_range(text.size()), space_char());
      if (text.size() != 0 && $urandom_range(11) == 0)
        text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255, 1));
    end
    case ($urandom_range(9))
      0:       len = LenW'(n_out + 1);
      1:       len = (n_out > 0) ? LenW'(n_out - 1) : '0;
      2:       len = LenW'($urandom);
      3:       len = ($urandom_range(1) == 0) ? LenMax : '0;
      default: len = LenW'(n_out);
    endcase
    if (len != want_len) apply_length(len);
    foreach (text[i]) send_char(text[i]);
    if (hold_before_end) hold_until_drained();
    send_char(ChEnd);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // full quad with '+' and '/', exact length
    apply_length(24'd3);
    send_text("+/z9");
    send_char(ChEnd);
    // two sextets, a space, padding, then a stray char that is dropped
    apply_length(24'd1);
    send_text("QQ =x");
    send_char(ChEnd);
    // three sextets and one pad: two tail bytes of zero
    apply_length(24'd2);
    send_text("AAA=");
    send_char(ChEnd);
    // zero length: first quad overflows, all-ones bytes never leave
    apply_length('0);
    send_text("////");
    send_char(ChEnd);
    // top byte value is invalid; the rest is dropped
    apply_length(LenMax);
    send_char(8'hFF);
    send_char(ChEnd);
    // lone sextet is ignored, whitespace skipped, result too short
    apply_length(24'd2);
    send_char("A");
    send_char(ChTab);
    send_char(ChCr);
    send_char(ChEnd);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_chars);
    int unsigned stop_at;
    int unsigned k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = chars_sent + n_chars;
    k = 0;
    while (chars_sent < stop_at) begin
      // first string of each round always waits for the output to drain before its end
      send_random_string(k == 0 || $urandom_range(9) == 0);
      k++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(30, 85, 170);
    test_random_traffic(85, 30, 170);
    test_random_traffic(0, 0, 170);

    // let the tail drain, then give the pipe a few more cycles
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (PipeDrain * 2) @(posedge clk);

    $display("Sent %0d characters in %0d strings under three idle mixes; %0d length writes.",
             chars_sent, strings_sent, len_writes);
    $display("Checked %0d result words, %0d field errors.", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
